// ===== hdl/isa_pkg.sv =====
// Shared types and constants for the indexed shift array.
`default_nettype none
package isa_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int LOC_W      = 7;
	localparam int CNT_W      = 7;
	localparam int OP_W       = 2;
	localparam int STAT_W     = 2;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int GROUP      = 8;
	localparam int NGROUP     = (CAPACITY + GROUP - 1) / GROUP;
	localparam int IN_BITS    = OP_W + LOC_W + DATA_WIDTH;
	localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = STAT_W + DATA_WIDTH + CNT_W;
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic                  shift_up;
		logic                  shift_down;
		logic [LOC_W-1:0]      loc;
		logic [DATA_WIDTH-1:0] data;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/indexed_shift_array.sv =====
// Indexed shift array: a row of storage cells with insert, delete and read requests.
//
// Channels: requests enter on s_tvalid/s_tready/s_tdata, results leave on
// m_tvalid/m_tready/m_tdata, one result per request, in request order.
// Insert and delete shift the whole row of cells in the cycle the request is
// taken, so a new request can be taken every cycle while the receiver does not stall.
// A read selects its entry through a two-level OR tree: groups of eight cells
// are reduced and registered, then the group results are reduced into the
// output register.
// Pipeline: two register stages; a result passes the tree stage register and then
// the output register before it appears on m_tvalid.
// Throughput: one request per cycle while m_tready stays high.
// When the receiver stalls, the output register and the tree stage hold and
// s_tready drops until the result ahead is taken; nothing is lost.
// Reset clears the count and the pipeline valid flags; cell contents are
// left as they are and are only read below the count.
`default_nettype none
module indexed_shift_array
	import isa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // operation, location, data_in
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata   // status, data_out, count
);

	logic [OP_W-1:0]       operation;
	logic [LOC_W-1:0]      location;
	logic [DATA_WIDTH-1:0] data_in;
	logic                  accept;
	logic                  advance;

	cell_cmd_t             cmd;
	status_t               status;
	logic [CNT_W-1:0]      count_next;
	logic                  read_ok;

	logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];
	logic [DATA_WIDTH-1:0] grp_or  [NGROUP];

	logic                  valid_s1;
	status_t               status_s1;
	logic [CNT_W-1:0]      count_s1;
	logic                  read_ok_s1;
	logic [DATA_WIDTH-1:0] grp_s1  [NGROUP];

	logic                  m_valid_q;
	logic [OUT_W-1:0]      m_data_q;
	logic [DATA_WIDTH-1:0] rd_all;

	assign operation = s_tdata[OP_W-1:0];
	assign location  = s_tdata[OP_W +: LOC_W];
	assign data_in   = s_tdata[OP_W+LOC_W +: DATA_WIDTH];

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && advance;

	isa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (operation),
		.location   (location),
		.data_in    (data_in),
		.cmd        (cmd),
		.status     (status),
		.count_next (count_next),
		.read_ok    (read_ok)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_q[i+1];
		end
		isa_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (IDX_W'(i)),
			.left  (left),
			.right (right),
			.entry (cell_q[i]),
			.rd    (cell_rd[i])
		);
	end

	// first level of the read tree: one OR per group of cells
	for (genvar g = 0; g < NGROUP; g++) begin : g_grp
		always_comb begin
			grp_or[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY)
					grp_or[g] = grp_or[g] | cell_rd[g * GROUP + k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s1  <= status;
			count_s1   <= count_next;
			read_ok_s1 <= read_ok;
			grp_s1     <= grp_or;
		end
	end

	always_comb begin
		rd_all = '0;
		for (int g = 0; g < NGROUP; g++)
			rd_all = rd_all | grp_s1[g];
		if (!read_ok_s1)
			rd_all = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (advance)
			m_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_data_q <= OUT_W'({count_s1, rd_all, status_s1});
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

// ===== hdl/isa_cell.sv =====
// One storage cell of the row: holds an entry, shifts with its neighbours.
`default_nettype none
module isa_cell
	import isa_pkg::*;
(
	input  wire logic                  clk,
	input  wire cell_cmd_t             cmd,
	input  wire logic [IDX_W-1:0]      idx,
	input  wire logic [DATA_WIDTH-1:0] left,
	input  wire logic [DATA_WIDTH-1:0] right,
	output logic      [DATA_WIDTH-1:0] entry,
	output logic      [DATA_WIDTH-1:0] rd
);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [LOC_W-1:0]      my_loc;
	logic                  hit;
	logic                  above;

	assign my_loc = LOC_W'(idx);
	assign hit    = (my_loc == cmd.loc);
	assign above  = (my_loc > cmd.loc);

	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			if (above)
				entry_q <= left;
			else if (hit)
				entry_q <= cmd.data;
		end else if (cmd.shift_down) begin
			if (above || hit)
				entry_q <= right;
		end
	end

	assign entry = entry_q;
	assign rd    = hit ? entry_q : '0;

endmodule
`default_nettype wire

// ===== hdl/isa_ctrl.sv =====
// Request decode, range checks and entry count.
`default_nettype none
module isa_ctrl
	import isa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [OP_W-1:0]       operation,
	input  wire logic [LOC_W-1:0]      location,
	input  wire logic [DATA_WIDTH-1:0] data_in,
	output cell_cmd_t                  cmd,
	output status_t                    status,
	output logic      [CNT_W-1:0]      count_next,
	output logic                       read_ok
);

	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             in_range;
	logic             up_ok;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign in_range = (CNT_W'(location) < count_q);

	always_comb begin
		up_ok      = 1'b0;
		cmd.shift_down = 1'b0;
		read_ok    = 1'b0;
		status     = ST_RANGE;
		unique case (operation)
			OP_INSERT: begin
				if (CNT_W'(location) > count_q)
					status = ST_RANGE;
				else if (full)
					status = ST_FULL;
				else begin
					status = ST_DONE;
					up_ok  = 1'b1;
				end
			end
			OP_DELETE: begin
				if (in_range) begin
					status         = ST_DONE;
					cmd.shift_down = accept;
				end
			end
			OP_READ: begin
				if (in_range) begin
					status  = ST_DONE;
					read_ok = 1'b1;
				end
			end
			default: status = ST_RANGE;
		endcase
		cmd.shift_up = up_ok && accept;
		cmd.loc      = location;
		cmd.data     = data_in;

		if (up_ok)
			count_next = count_q + 1'b1;
		else if (operation == OP_DELETE && in_range)
			count_next = count_q - 1'b1;
		else
			count_next = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (accept)
			count_q <= count_next;
	end

endmodule
`default_nettype wire

// ===== hdl/isa_checker.sv =====
// Port-level checks for the indexed shift array, bound to the top level.
`default_nettype none
module isa_checker
	import isa_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic [IN_W-1:0]  s_tdata,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	logic [STAT_W-1:0] st;
	logic [CNT_W-1:0]  cnt;

	assign st  = m_tdata[STAT_W-1:0];
	assign cnt = m_tdata[STAT_W+DATA_WIDTH +: CNT_W];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == ST_FULL |-> cnt == CNT_W'(CAPACITY))
		else $error("full status with count below capacity");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ST_DONE |-> m_tdata[STAT_W +: DATA_WIDTH] == '0)
		else $error("refused request returned data");

endmodule

bind indexed_shift_array isa_checker u_isa_checker (.*);
`default_nettype wire

// ===== sim/tb_indexed_shift_array.sv =====
`timescale 1ns / 1ps
// Testbench for the indexed shift array: queued random and directed requests, shadow-array checking.
module tb_indexed_shift_array;
	import isa_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int              IDLE_LIMIT = 4000;
	localparam int              END_WAIT = 10;
	localparam int              PHASE_ITEMS = 435;

	// last member sits in the lowest bits, matching the tdata layout
	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		logic [LOC_W-1:0]      loc;
		logic [OP_W-1:0]       op;
	} arr_req_t;

	typedef struct packed {
		status_t               status;
		logic [DATA_WIDTH-1:0] rdata;
		logic [CNT_W-1:0]      count;
	} arr_res_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;  // operation, location, data_in
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // status, data_out, count

	arr_req_t pending_requests[$];
	arr_res_t expected_results[$];

	// shadow copy of the array contents
	logic [DATA_WIDTH-1:0] shadow_entries[CAPACITY];
	int                    shadow_count = 0;

	// count as seen by the request generator, ahead of the driver
	int gen_count = 0;
	bit growing = 1'b1;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int idle_cycles = 0;
	bit req_taken = 1'b0;

	indexed_shift_array dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic arr_res_t apply_request(arr_req_t r);
		arr_res_t res;
		int       i;
		res.status = ST_DONE;
		res.rdata = '0;
		case (r.op)
			OP_INSERT: begin
				if (r.loc > shadow_count)
					res.status = ST_RANGE;
				else if (shadow_count >= CAPACITY)
					res.status = ST_FULL;
				else begin
					for (i = shadow_count; i > r.loc; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[r.loc] = r.data;
					shadow_count++;
				end
			end
			OP_DELETE: begin
				if (r.loc >= shadow_count)
					res.status = ST_RANGE;
				else begin
					for (i = r.loc; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
				end
			end
			OP_READ: begin
				if (r.loc >= shadow_count)
					res.status = ST_RANGE;
				else
					res.rdata = shadow_entries[r.loc];
			end
			default: res.status = ST_RANGE;
		endcase
		res.count = shadow_count[CNT_W-1:0];
		return res;
	endfunction

	// queue a request and track the count it leaves behind
	task automatic push_request(logic [OP_W-1:0] op, int loc, logic [DATA_WIDTH-1:0] data);
		arr_req_t r;
		r.op = op;
		r.loc = loc[LOC_W-1:0];
		r.data = data;
		pending_requests.push_back(r);
		if (op == OP_INSERT && loc <= gen_count && gen_count < CAPACITY)
			gen_count++;
		else if (op == OP_DELETE && loc < gen_count)
			gen_count--;
	endtask

	// mostly in-range requests; fill and drain swings take the array to both ends
	task automatic random_request();
		logic [OP_W-1:0]       op;
		logic [DATA_WIDTH-1:0] data;
		int                    loc;
		int                    top;
		int                    roll;
		roll = $urandom_range(99);
		if (growing)
			op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_READ : OP_DELETE;
		else
			op = (roll < 65) ? OP_DELETE : (roll < 85) ? OP_READ : OP_INSERT;
		if ($urandom_range(99) < 88) begin
			top = (op == OP_INSERT) ? gen_count : gen_count - 1;
			loc = (top < 0) ? 0 : $urandom_range(top);
		end else
			loc = $urandom_range(CAPACITY);
		roll = $urandom_range(9);
		if (roll == 0)
			data = 32'h7fff_ffff;
		else if (roll == 1)
			data = 32'h8000_0000;
		else
			data = $urandom;
		push_request(op, loc, data);
		if (gen_count == CAPACITY && $urandom_range(3) == 0)
			growing = 1'b0;
		else if (gen_count == 0)
			growing = 1'b1;
		else if ($urandom_range(59) == 0)
			growing = ~growing;
	endtask

	// sender pauses here until the array has answered everything
	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// driver: new request or idle at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || req_taken) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= {{(IN_W-IN_BITS){1'b0}}, pending_requests.pop_front()};
					s_tvalid <= 1'b1;
				end else
					s_tvalid <= 1'b0;
			end
			req_taken = 1'b0;
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor: check results, then predict the request taken at this edge
	always @(posedge clk) begin
		arr_res_t exp_res;
		status_t  got_status;
		logic [DATA_WIDTH-1:0] got_data;
		logic [CNT_W-1:0]      got_count;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_status = status_t'(m_tdata[STAT_W-1:0]);
				got_data = m_tdata[STAT_W +: DATA_WIDTH];
				got_count = m_tdata[STAT_W+DATA_WIDTH +: CNT_W];
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d data %0d count %0d",
						got_status, $signed(got_data), got_count);
					fail_count++;
				end else begin
					exp_res = expected_results.pop_front();
					if (got_status !== exp_res.status) begin
						$error("status: expected %0d, got %0d", exp_res.status, got_status);
						fail_count++;
					end
					if (got_data !== exp_res.rdata) begin
						$error("data_out: expected %0d, got %0d",
							$signed(exp_res.rdata), $signed(got_data));
						fail_count++;
					end
					if (got_count !== exp_res.count) begin
						$error("count: expected %0d, got %0d", exp_res.count, got_count);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_request(arr_req_t'(s_tdata[IN_BITS-1:0])));
				req_taken = 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int ph;
		int n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty array, both data extremes, ends and middle, bad indexes
		push_request(OP_READ, 0, 32'h0);
		push_request(OP_DELETE, 0, 32'h0);
		push_request(OP_INSERT, 1, 32'h1234_5678);
		push_request(OP_INSERT, 0, 32'h7fff_ffff);
		push_request(OP_INSERT, 0, 32'h8000_0000);
		push_request(OP_INSERT, 2, 32'hffff_ffff);
		push_request(OP_INSERT, 1, 32'h0);
		push_request(OP_READ, 0, 32'hffff_ffff);
		push_request(OP_READ, 3, 32'h0);
		push_request(OP_READ, 4, 32'h0);
		push_request(OP_READ, CAPACITY, 32'h0);
		push_request(OP_UNUSED, 0, 32'h5a5a_5a5a);
		push_request(OP_DELETE, 1, 32'h0);
		push_request(OP_DELETE, 2, 32'h0);
		push_request(OP_DELETE, 5, 32'h0);
		push_request(OP_INSERT, CAPACITY, 32'h0);
		push_request(OP_INSERT, 0, 32'h5555_5555);
		push_request(OP_INSERT, 1, 32'haaaa_aaaa);
		push_request(OP_READ, 1, 32'h0);
		push_request(OP_READ, 0, 32'h0);
		push_request(OP_UNUSED, CAPACITY, 32'h0);
		push_request(OP_DELETE, 0, 32'h0);
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				random_request();
			wait_drained();
		end

		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/isa_pkg.sv
hdl/isa_cell.sv
hdl/isa_ctrl.sv
hdl/indexed_shift_array.sv
hdl/isa_checker.sv
sim/tb_indexed_shift_array.sv
